FILE: rtl/rtd_pkg.sv
// rtd_pkg: shared widths, fixed-point constants and payload types for the
// rtd resistance-to-temperature pipeline
// no dependencies
`default_nettype none

package rtd_pkg;

  // field and register widths
  localparam int READING_BITS  = 15;
  localparam int OUT_FRAC_BITS = 8;
  localparam int REF_W         = 14;
  localparam int NOM_W         = 10;
  localparam int TEMP_W        = 19;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REF_RES = 1'b0,
    CFG_NOM_RES = 1'b1
  } cfg_reg_e;

  localparam logic [REF_W-1:0] REF_RESET = REF_W'(4000);
  localparam logic [NOM_W-1:0] NOM_RESET = NOM_W'(1000);

  // divider: x = (reading*ref << (32-READING_BITS)) / nom, unsigned q32
  localparam int NUM_W      = READING_BITS + REF_W;
  localparam int SAT_SH     = READING_BITS + 3;
  localparam int Q_W        = 35;
  localparam int XC_W       = Q_W + 1;
  localparam int DIV_STEPS  = 5;
  localparam int DIV_STAGES = Q_W / DIV_STEPS;
  localparam logic [XC_W-1:0] X_ONE = XC_W'(1) << 32;
  localparam logic [XC_W-1:0] X_MAX = XC_W'(1) << 35;

  // quadratic inverse
  localparam int P_W  = 32;
  localparam int K_W  = 29;
  localparam int D_W  = 35;
  localparam int D_LO = 18;
  localparam int U_W  = 25;
  localparam int RAD_W = 64;
  localparam logic [P_W-1:0] P_Q20 =
    P_W'((64'd781660 * 64'd1048576 + 64'd115) / 64'd231);
  localparam logic [K_W-1:0] K_Q8 =
    K_W'((64'd400000000 * 64'd256 + 64'd115) / 64'd231);
  localparam logic [RAD_W-1:0] P2 = RAD_W'(64'(P_Q20) * 64'(P_Q20));

  // square root: two result bits per stage
  localparam int ROOT_W     = 32;
  localparam int SQ_STEPS   = 2;
  localparam int SQ_STAGES  = ROOT_W / SQ_STEPS;
  localparam int SQ_REM_W   = ROOT_W + 4;
  localparam int T20_W      = P_W + 1;

  // sub-zero polynomial, q30 coefficients
  // horner partial sums reach about 242 in q30, so the multiplier takes the full sum
  localparam int POLY_TERMS = 6;
  localparam int POLY_STEPS = POLY_TERMS - 1;
  localparam int PC_W       = 40;
  localparam int ACC_W      = 40;
  localparam int ACC_MUL_W  = ACC_W;
  localparam int PROD_W     = ACC_MUL_W + U_W + 1;
  localparam int POLY_SH    = 24;

  localparam longint C0_MAG = ((longint'(24202) <<< 30) + 50) / 100;
  localparam longint C1_MAG = ((longint'(22228) <<< 30) + 50) / 100;
  localparam longint C2_MAG = ((longint'(25859) <<< 30) + 500) / 1000;
  localparam longint C3_MAG = ((longint'(4826) <<< 30) + 500) / 1000;
  localparam longint C4_MAG = ((longint'(28183) <<< 30) + 5000) / 10000;
  localparam longint C5_MAG = ((longint'(15243) <<< 30) + 5000) / 10000;

  localparam logic signed [PC_W-1:0] POLY_C [POLY_TERMS] = '{
    PC_W'(-C0_MAG), PC_W'(C1_MAG), PC_W'(C2_MAG),
    PC_W'(-C3_MAG), PC_W'(-C4_MAG), PC_W'(C5_MAG)
  };

  // output rounding and saturation
  localparam int T20_SH  = 20 - OUT_FRAC_BITS;
  localparam int POLY_RS = 30 - OUT_FRAC_BITS;
  localparam int TV_W    = ACC_W + 1;
  localparam logic signed [TV_W-1:0] T_LO = -(TV_W'(1) <<< (TEMP_W - 1));
  localparam logic signed [TV_W-1:0] T_HI = (TV_W'(1) <<< (TEMP_W - 1)) - TV_W'(1);

  typedef struct packed {
    logic [RAD_W-1:0] rad;
    logic [U_W-1:0]   u;
  } rad_item_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic [U_W-1:0]    u;
  } root_item_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic signed [T20_W-1:0] t20;
  } poly_item_t;

endpackage

`default_nettype wire

FILE: rtl/rtd_resistance_to_temperature.sv
// rtd_resistance_to_temperature: top level of the rtd ratio-to-temperature pipeline
// depends on rtd_pkg, rtd_div, rtd_rad, rtd_sqrt, rtd_poly
//
// usage:
// - input channel (in_valid_i / in_stall_o / reading_i): one 15-bit ratio reading
//   per transfer, one transfer per cycle sustained while in_stall_o is low
// - output channel (out_valid_o / out_stall_i): temperature in signed q.8 degrees
//   plus below_zero, exactly one result transfer per reading, in order
// - config port: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 reference resistor, 1 nominal sensor resistance); write only when idle
// - pipeline from input transfer to result valid: 8 divider stages,
//   4 radicand stages, 16 square-root stages, 10 polynomial stages, output register
// - throughput: one item per cycle while no stall holds the pipeline, set by the
//   fully pipelined divider, square root and horner multipliers
// - reset: all valid bits clear, registers return to 4000 ohm and 1000 ohm
// - stall: while a result waits and out_stall_i is high the whole pipeline
//   holds and in_stall_o is raised; nothing is dropped or repeated
`default_nettype none

module rtd_resistance_to_temperature import rtd_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [READING_BITS-1:0] reading_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic signed [TEMP_W-1:0]     temperature_q8_o,
  output logic                         below_zero_o,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data_i
);

  logic [REF_W-1:0] ref_q;
  logic [NOM_W-1:0] nom_q;
  logic             en;

  logic             div_valid;
  logic [XC_W-1:0]  div_xc;
  logic             rad_valid;
  rad_item_t        rad_item;
  logic             sq_valid;
  root_item_t       sq_item;
  logic             poly_valid;
  poly_item_t       poly_item;

  logic                    out_valid_q;
  logic signed [TEMP_W-1:0] temp_q;
  logic                    below_q;

  logic                    below_d;
  logic signed [T20_W:0]   tq_d;
  logic signed [TV_W-1:0]  tp_d;
  logic signed [TV_W-1:0]  tv_d;
  logic signed [TV_W-1:0]  ts_d;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= REF_RESET;
      nom_q <= NOM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_REF_RES: ref_q <= cfg_data_i[REF_W-1:0];
        CFG_NOM_RES: nom_q <= cfg_data_i[NOM_W-1:0];
      endcase
    end
  end

  // one advance signal: everything moves unless a waiting result is stalled
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  rtd_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_valid_i),
    .reading_i (reading_i),
    .ref_i     (ref_q),
    .nom_i     (nom_q),
    .valid_o   (div_valid),
    .xc_o      (div_xc)
  );

  rtd_rad u_rad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_valid),
    .xc_i    (div_xc),
    .valid_o (rad_valid),
    .item_o  (rad_item)
  );

  rtd_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rad_valid),
    .item_i  (rad_item),
    .valid_o (sq_valid),
    .item_o  (sq_item)
  );

  rtd_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .item_i  (sq_item),
    .valid_o (poly_valid),
    .item_o  (poly_item)
  );

  // branch select: polynomial when the quadratic result is negative,
  // then round half up to q.8 and clamp to the output range
  always_comb begin
    below_d = poly_item.t20[T20_W-1];
    tq_d    = ((T20_W+1)'(poly_item.t20) + (T20_W+1)'(1 <<< (T20_SH - 1))) >>> T20_SH;
    tp_d    = (TV_W'(poly_item.acc) + (TV_W'(1) <<< (POLY_RS - 1))) >>> POLY_RS;
    tv_d    = below_d ? tp_d : TV_W'(tq_d);
    if (tv_d < T_LO) begin
      ts_d = T_LO;
    end else if (tv_d > T_HI) begin
      ts_d = T_HI;
    end else begin
      ts_d = tv_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= poly_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && poly_valid) begin
      temp_q  <= ts_d[TEMP_W-1:0];
      below_q <= below_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign temperature_q8_o = temp_q;
  assign below_zero_o     = below_q;

endmodule

`default_nettype wire

FILE: rtl/rtd_div.sv
// rtd_div: pipelined restoring divider producing the clamped q32 ratio x
// depends on rtd_pkg
`default_nettype none

module rtd_div import rtd_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    valid_i,
  input  wire logic [READING_BITS-1:0] reading_i,
  input  wire logic [REF_W-1:0]        ref_i,
  input  wire logic [NOM_W-1:0]        nom_i,
  output logic                         valid_o,
  output logic [XC_W-1:0]              xc_o
);

  logic [NOM_W-1:0] nom_eff;
  logic [NUM_W-1:0] num;

  logic             pv_q;
  logic             psat_q;
  logic [NOM_W-1:0] prem_q;
  logic [Q_W-1:0]   psh_q;

  logic             v_in   [DIV_STAGES];
  logic             sat_in [DIV_STAGES];
  logic [NOM_W-1:0] rem_in [DIV_STAGES];
  logic [Q_W-1:0]   sh_in  [DIV_STAGES];
  logic [NOM_W-1:0] rem_d  [DIV_STAGES];
  logic [Q_W-1:0]   sh_d   [DIV_STAGES];
  logic             v_q    [DIV_STAGES];
  logic             sat_q  [DIV_STAGES];
  logic [NOM_W-1:0] rem_q  [DIV_STAGES];
  logic [Q_W-1:0]   sh_q   [DIV_STAGES];

  assign nom_eff = (nom_i == '0) ? NOM_W'(1) : nom_i;
  assign num     = NUM_W'(reading_i) * NUM_W'(ref_i);

  // prep stage: product, overflow check, first partial remainder
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (en_i) begin
      pv_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      psat_q <= num >= (NUM_W'(nom_eff) << SAT_SH);
      prem_q <= num[SAT_SH +: NOM_W];
      psh_q  <= {num[SAT_SH-1:0], {(Q_W - SAT_SH){1'b0}}};
    end
  end

  always_comb begin
    v_in[0]   = pv_q;
    sat_in[0] = psat_q;
    rem_in[0] = prem_q;
    sh_in[0]  = psh_q;
    for (int s = 1; s < DIV_STAGES; s++) begin
      v_in[s]   = v_q[s-1];
      sat_in[s] = sat_q[s-1];
      rem_in[s] = rem_q[s-1];
      sh_in[s]  = sh_q[s-1];
    end
  end

  always_comb begin
    logic [NOM_W:0] r;
    logic           qb;
    for (int s = 0; s < DIV_STAGES; s++) begin
      rem_d[s] = rem_in[s];
      sh_d[s]  = sh_in[s];
      for (int k = 0; k < DIV_STEPS; k++) begin
        r  = {rem_d[s], sh_d[s][Q_W-1]};
        qb = r >= {1'b0, nom_eff};
        if (qb) begin
          r = r - {1'b0, nom_eff};
        end
        rem_d[s] = r[NOM_W-1:0];
        sh_d[s]  = {sh_d[s][Q_W-2:0], qb};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        v_q[s] <= 1'b0;
      end
    end else if (en_i) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        v_q[s] <= v_in[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        sat_q[s] <= sat_in[s];
        rem_q[s] <= rem_d[s];
        sh_q[s]  <= sh_d[s];
      end
    end
  end

  assign valid_o = v_q[DIV_STAGES-1];
  assign xc_o    = sat_q[DIV_STAGES-1] ? X_MAX : {1'b0, sh_q[DIV_STAGES-1]};

endmodule

`default_nettype wire

FILE: rtl/rtd_rad.sv
// rtd_rad: radicand of the quadratic inverse, p^2 + k*(1 - x), saturated at zero
// depends on rtd_pkg
`default_nettype none

module rtd_rad import rtd_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire logic [XC_W-1:0] xc_i,
  output logic                 valid_o,
  output rad_item_t            item_o
);

  logic                  gt_d;
  logic [XC_W-1:0]       dw_d;
  logic [XC_W-1:0]       uw_d;

  logic                  v1_q, v2_q, v3_q, v4_q;
  logic                  gt1_q, gt2_q, gt3_q;
  logic [D_W-1:0]        d1_q;
  logic [U_W-1:0]        u1_q, u2_q, u3_q;
  logic [K_W+D_LO-1:0]   pplo_q;
  logic [K_W+D_W-D_LO-1:0] pphi_q;
  logic [RAD_W-1:0]      sub_q;
  rad_item_t             out_q;
  logic [RAD_W-1:0]      rad_d;

  assign gt_d = xc_i > X_ONE;
  assign dw_d = gt_d ? (xc_i - X_ONE) : (X_ONE - xc_i);
  assign uw_d = (gt_d ? X_ONE : xc_i) >> 8;

  always_comb begin
    if (gt3_q) begin
      rad_d = (sub_q >= P2) ? '0 : (P2 - sub_q);
    end else begin
      rad_d = P2 + sub_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gt1_q     <= gt_d;
      d1_q      <= dw_d[D_W-1:0];
      u1_q      <= uw_d[U_W-1:0];
      gt2_q     <= gt1_q;
      u2_q      <= u1_q;
      pplo_q    <= K_Q8 * d1_q[D_LO-1:0];
      pphi_q    <= K_Q8 * d1_q[D_W-1:D_LO];
      gt3_q     <= gt2_q;
      u3_q      <= u2_q;
      sub_q     <= RAD_W'(pplo_q) + (RAD_W'(pphi_q) << D_LO);
      out_q.rad <= rad_d;
      out_q.u   <= u3_q;
    end
  end

  assign valid_o = v4_q;
  assign item_o  = out_q;

endmodule

`default_nettype wire

FILE: rtl/rtd_sqrt.sv
// rtd_sqrt: pipelined digit-by-digit floor square root of the 64-bit radicand
// depends on rtd_pkg
`default_nettype none

module rtd_sqrt import rtd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire logic       valid_i,
  input  wire rad_item_t  item_i,
  output logic            valid_o,
  output root_item_t      item_o
);

  logic                v_in    [SQ_STAGES];
  logic [RAD_W-1:0]    src_in  [SQ_STAGES];
  logic [SQ_REM_W-1:0] rem_in  [SQ_STAGES];
  logic [ROOT_W-1:0]   root_in [SQ_STAGES];
  logic [U_W-1:0]      u_in    [SQ_STAGES];
  logic [RAD_W-1:0]    src_d   [SQ_STAGES];
  logic [SQ_REM_W-1:0] rem_d   [SQ_STAGES];
  logic [ROOT_W-1:0]   root_d  [SQ_STAGES];
  logic                v_q     [SQ_STAGES];
  logic [RAD_W-1:0]    src_q   [SQ_STAGES];
  logic [SQ_REM_W-1:0] rem_q   [SQ_STAGES];
  logic [ROOT_W-1:0]   root_q  [SQ_STAGES];
  logic [U_W-1:0]      u_q     [SQ_STAGES];

  always_comb begin
    v_in[0]    = valid_i;
    src_in[0]  = item_i.rad;
    rem_in[0]  = '0;
    root_in[0] = '0;
    u_in[0]    = item_i.u;
    for (int s = 1; s < SQ_STAGES; s++) begin
      v_in[s]    = v_q[s-1];
      src_in[s]  = src_q[s-1];
      rem_in[s]  = rem_q[s-1];
      root_in[s] = root_q[s-1];
      u_in[s]    = u_q[s-1];
    end
  end

  always_comb begin
    logic [SQ_REM_W-1:0] trial;
    for (int s = 0; s < SQ_STAGES; s++) begin
      src_d[s]  = src_in[s];
      rem_d[s]  = rem_in[s];
      root_d[s] = root_in[s];
      for (int k = 0; k < SQ_STEPS; k++) begin
        rem_d[s] = {rem_d[s][SQ_REM_W-3:0], src_d[s][RAD_W-1 -: 2]};
        src_d[s] = {src_d[s][RAD_W-3:0], 2'b00};
        trial    = SQ_REM_W'({root_d[s], 2'b01});
        if (rem_d[s] >= trial) begin
          rem_d[s]  = rem_d[s] - trial;
          root_d[s] = {root_d[s][ROOT_W-2:0], 1'b1};
        end else begin
          root_d[s] = {root_d[s][ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SQ_STAGES; s++) begin
        v_q[s] <= 1'b0;
      end
    end else if (en_i) begin
      for (int s = 0; s < SQ_STAGES; s++) begin
        v_q[s] <= v_in[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < SQ_STAGES; s++) begin
        src_q[s]  <= src_d[s];
        rem_q[s]  <= rem_d[s];
        root_q[s] <= root_d[s];
        u_q[s]    <= u_in[s];
      end
    end
  end

  assign valid_o     = v_q[SQ_STAGES-1];
  assign item_o.root = root_q[SQ_STAGES-1];
  assign item_o.u    = u_q[SQ_STAGES-1];

endmodule

`default_nettype wire

FILE: rtl/rtd_poly.sv
// rtd_poly: quadratic result p - root and the fifth-order sub-zero polynomial,
// horner form with one multiply stage and one add stage per horner step; depends on rtd_pkg
`default_nettype none

module rtd_poly import rtd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  wire root_item_t  item_i,
  output logic             valid_o,
  output poly_item_t       item_o
);

  logic                        vm_in  [POLY_STEPS];
  logic signed [ACC_MUL_W-1:0] am_in  [POLY_STEPS];
  logic        [U_W-1:0]       um_in  [POLY_STEPS];
  logic signed [T20_W-1:0]     tm_in  [POLY_STEPS];
  logic signed [PROD_W-1:0]    prod_d [POLY_STEPS];
  logic signed [ACC_W-1:0]     acc_d  [POLY_STEPS];

  logic                        vm_q   [POLY_STEPS];
  logic signed [PROD_W-1:0]    prod_q [POLY_STEPS];
  logic        [U_W-1:0]       um_q   [POLY_STEPS];
  logic signed [T20_W-1:0]     tm_q   [POLY_STEPS];
  logic                        va_q   [POLY_STEPS];
  logic signed [ACC_W-1:0]     acc_q  [POLY_STEPS];
  logic        [U_W-1:0]       ua_q   [POLY_STEPS];
  logic signed [T20_W-1:0]     ta_q   [POLY_STEPS];

  always_comb begin
    vm_in[0] = valid_i;
    am_in[0] = ACC_MUL_W'(POLY_C[POLY_TERMS-1]);
    um_in[0] = item_i.u;
    tm_in[0] = $signed({1'b0, P_Q20}) - $signed({1'b0, item_i.root});
    for (int j = 1; j < POLY_STEPS; j++) begin
      vm_in[j] = va_q[j-1];
      am_in[j] = ACC_MUL_W'(acc_q[j-1]);
      um_in[j] = ua_q[j-1];
      tm_in[j] = ta_q[j-1];
    end
  end

  always_comb begin
    logic signed [PROD_W-1:0] sh;
    for (int j = 0; j < POLY_STEPS; j++) begin
      prod_d[j] = am_in[j] * $signed({1'b0, um_in[j]});
      sh        = prod_q[j] >>> POLY_SH;
      acc_d[j]  = ACC_W'(sh + PROD_W'(POLY_C[POLY_STEPS-1-j]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < POLY_STEPS; j++) begin
        vm_q[j] <= 1'b0;
        va_q[j] <= 1'b0;
      end
    end else if (en_i) begin
      for (int j = 0; j < POLY_STEPS; j++) begin
        vm_q[j] <= vm_in[j];
        va_q[j] <= vm_q[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < POLY_STEPS; j++) begin
        prod_q[j] <= prod_d[j];
        um_q[j]   <= um_in[j];
        tm_q[j]   <= tm_in[j];
        acc_q[j]  <= acc_d[j];
        ua_q[j]   <= um_q[j];
        ta_q[j]   <= tm_q[j];
      end
    end
  end

  assign valid_o    = va_q[POLY_STEPS-1];
  assign item_o.acc = acc_q[POLY_STEPS-1];
  assign item_o.t20 = ta_q[POLY_STEPS-1];

endmodule

`default_nettype wire

FILE: test/tb.sv
// tb: self-checking testbench for rtd_resistance_to_temperature
// depends on rtd_pkg and the rtd pipeline rtl; predicts every temperature in
// fixed point and compares each result transfer against the oldest prediction
`default_nettype none

module tb;
  import rtd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 39;
  localparam int MAX_CYCLES = 1500000;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic                     below;
  } temp_result_t;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [READING_BITS-1:0] reading;
  logic out_valid, out_stall;
  logic signed [TEMP_W-1:0] temperature;
  logic below_zero;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  // mirror of the two configuration registers
  logic [REF_W-1:0] ref_ohm;
  logic [NOM_W-1:0] nom_ohm;

  temp_result_t expected_temps[$];
  int mismatches;
  int cycle_count;
  bit long_hold;    // receiver holds off for a long stretch
  bit stall_random; // receiver stalls at random

  rtd_resistance_to_temperature uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .reading_i(reading),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .temperature_q8_o(temperature), .below_zero_o(below_zero),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // floor division by 2^s of a signed value
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint coef_q30(longint n, longint d);
    return ((n <<< 30) + d / 2) / d;
  endfunction

  // temperature from one reading under the current register values
  function automatic temp_result_t predict_temperature(logic [READING_BITS-1:0] rd);
    longint unsigned nom, x, xc, p_q20, k_q8, p2, rad, sub, one_q32, xu;
    longint t20, t, u, acc;
    longint c[6];
    temp_result_t r;
    one_q32 = 64'd1 << 32;
    p_q20 = (64'd781660 * 64'd1048576 + 64'd115) / 64'd231;
    k_q8  = (64'd400000000 * 64'd256 + 64'd115) / 64'd231;
    p2 = p_q20 * p_q20;
    c[0] = -coef_q30(24202, 100);
    c[1] = coef_q30(22228, 100);
    c[2] = coef_q30(25859, 1000);
    c[3] = -coef_q30(4826, 1000);
    c[4] = -coef_q30(28183, 10000);
    c[5] = coef_q30(15243, 10000);
    nom = (nom_ohm == 0) ? 64'd1 : 64'(nom_ohm);
    x = ((64'(rd) * 64'(ref_ohm)) << (32 - READING_BITS)) / nom;
    xc = (x > (64'd8 << 32)) ? (64'd8 << 32) : x;
    if (xc <= one_q32) begin
      rad = p2 + k_q8 * (one_q32 - xc);
    end else begin
      sub = k_q8 * (xc - one_q32);
      rad = (sub >= p2) ? 64'd0 : p2 - sub;
    end
    t20 = longint'(p_q20) - longint'(int_sqrt(rad));
    r.below = 1'b0;
    if (t20 >= 0) begin
      t = floor_shift(t20 + (64'sd1 <<< (19 - OUT_FRAC_BITS)), 20 - OUT_FRAC_BITS);
    end else begin
      xu = (x > one_q32) ? one_q32 : x;
      u = longint'(xu >> 8);
      acc = c[5];
      for (int k = 4; k >= 0; k--) acc = c[k] + floor_shift(acc * u, 24);
      t = floor_shift(acc + (64'sd1 <<< (29 - OUT_FRAC_BITS)), 30 - OUT_FRAC_BITS);
      r.below = 1'b1;
    end
    if (t < -(64'sd1 <<< (TEMP_W - 1))) t = -(64'sd1 <<< (TEMP_W - 1));
    if (t > (64'sd1 <<< (TEMP_W - 1)) - 1) t = (64'sd1 <<< (TEMP_W - 1)) - 1;
    r.temp = t[TEMP_W-1:0];
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int gap_cycles();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one reading transfer; prediction is queued when it is accepted
  // valid stays up after the transfer so readings can follow back to back,
  // wait_drained drops it
  task automatic send_reading(logic [READING_BITS-1:0] rd, bit with_gap);
    int gap;
    gap = with_gap ? gap_cycles() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    reading  <= rd;
    do @(posedge clk); while (in_stall);
    expected_temps.push_back(predict_temperature(rd));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_temps.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    if (idx == CFG_REF_RES) ref_ohm = value[REF_W-1:0];
    else nom_ohm = value[NOM_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // checker: each result transfer against the oldest prediction
  always @(posedge clk) begin
    temp_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_temps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: temp %0d below %0b", temperature, below_zero);
      end else begin
        want = expected_temps.pop_front();
        if (want.temp !== temperature || want.below !== below_zero) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: temp exp %0d got %0d, below exp %0b got %0b",
                     want.temp, temperature, want.below, below_zero);
        end
      end
    end
  end

  // receiver stall: random gaps, or one long hold-off counted here
  always @(negedge clk) begin
    if (long_hold) begin
      out_stall <= 1'b1;
      repeat (300) @(negedge clk);
      long_hold = 1'b0;
      out_stall <= 1'b0;
    end else if (stall_random) begin
      out_stall <= ($urandom_range(0, 99) < 20);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // readings at the field extremes and the zero crossing
  task automatic test_directed();
    logic [READING_BITS-1:0] rd_list[$];
    rd_list = '{15'd0, 15'd1, 15'd8191, 15'd8192, 15'd8193, 15'd4096, 15'd6000,
                15'd16384, 15'd32767, 15'd32766, 15'h5555, 15'h2AAA, 15'd12000};
    foreach (rd_list[i]) send_reading(rd_list[i], 1'b0);
    wait_drained();
  endtask

  // register extremes, including a zero nominal and huge ratios
  task automatic test_register_settings();
    logic [CFG_DATA_W-1:0] refs[$];
    logic [CFG_DATA_W-1:0] noms[$];
    refs = '{14'd100, 14'd16383, 14'd400, 14'd1000, 14'd16000};
    noms = '{14'd100, 14'd1000, 14'd0, 14'd1023, 14'd100};
    foreach (refs[i]) begin
      write_reg(CFG_REF_RES, refs[i]);
      write_reg(CFG_NOM_RES, noms[i]);
      send_reading(15'd0, 1'b0);
      send_reading(15'd32767, 1'b0);
      send_reading(READING_BITS'($urandom), 1'b0);
      wait_drained();
    end
  endtask

  // random readings with random gaps and receiver stalls
  task automatic test_random(int count);
    logic [READING_BITS-1:0] rd;
    stall_random = 1'b1;
    for (int i = 0; i < count; i++) begin
      if (i % 200 == 0) begin
        wait_drained();
        // pt100 / pt1000 style settings mostly, sometimes anything
        if ($urandom_range(0, 2) == 0) begin
          write_reg(CFG_REF_RES, CFG_DATA_W'($urandom));
          write_reg(CFG_NOM_RES, CFG_DATA_W'($urandom_range(0, 1023)));
        end else if ($urandom_range(0, 1) == 0) begin
          write_reg(CFG_REF_RES, 14'd400);
          write_reg(CFG_NOM_RES, 14'd100);
        end else begin
          write_reg(CFG_REF_RES, 14'd4000);
          write_reg(CFG_NOM_RES, 14'd1000);
        end
      end
      // half the readings land near the sensor's working range
      if ($urandom_range(0, 1) == 0)
        rd = READING_BITS'($urandom);
      else
        rd = READING_BITS'(((nom_ohm + 1) * 32768 / (ref_ohm + 1)) * $urandom_range(30, 300) / 100);
      send_reading(rd, 1'b1);
    end
    wait_drained();
  endtask

  // long receiver hold-off while readings keep coming, then a full drain
  task automatic test_backpressure();
    stall_random = 1'b0;
    long_hold = 1'b1;
    for (int i = 0; i < 80; i++) send_reading(READING_BITS'($urandom), 1'b0);
    wait_drained();
    stall_random = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    reading = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_REF_RES;
    cfg_data = '0;
    ref_ohm = REF_RESET;
    nom_ohm = NOM_RESET;
    mismatches = 0;
    cycle_count = 0;
    long_hold = 1'b0;
    stall_random = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_register_settings();
    test_backpressure();
    test_random(1000);

    if (mismatches == 0 && expected_temps.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule

`default_nettype wire
